>>> hdl/ead_pkg.sv
// Shared types, constants and helper functions for the exponential ADSR envelope.
// No dependencies; every other file imports this package.
`default_nettype none

package ead_pkg;

  // Sizes
  localparam int unsigned GainTableDepth = 1024;
  localparam int unsigned TblBits        = $clog2(GainTableDepth);
  localparam int unsigned SampleWidth    = 24;
  localparam int unsigned QDepth         = 2;
  localparam int unsigned QPtrW          = $clog2(QDepth);
  localparam int unsigned LevelW         = 25;
  localparam int unsigned StepW          = 24;
  localparam int unsigned DivW           = 34;
  localparam int unsigned DivCntW        = $clog2(DivW + 1);
  localparam int unsigned TermW          = 31;
  localparam int unsigned SumW           = 33;
  localparam int unsigned CfgW           = 18;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned SeriesTerms    = 12;

  // Arithmetic constants
  localparam logic [StepW-1:0]         FloorSpan   = 24'd11796480;
  localparam logic signed [LevelW-1:0] FloorDb     = -25'sd11796480;
  localparam logic [29:0]              Ln2Q30      = 30'd744261118;
  localparam logic [29:0]              OctPerDbQ32 = 30'd713378626;
  localparam logic [TermW-1:0]         OneQ30      = 31'h4000_0000;
  localparam logic signed [16:0]       SustainMin  = -17'sd46080;

  typedef enum logic [1:0] {
    OP_AUDIO    = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_RSVD     = 2'd3
  } ead_op_e;

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_ON    = 2'd1,
    KIND_OFF   = 2'd2,
    KIND_NONE  = 2'd3
  } ead_kind_e;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } ead_phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_RATE   = 3'd0,
    CFG_ATTACK_MS     = 3'd1,
    CFG_DECAY_MS      = 3'd2,
    CFG_RELEASE_MS    = 3'd3,
    CFG_SUSTAIN_LEVEL = 3'd4,
    CFG_SUSTAIN_LOSS  = 3'd5,
    CFG_SUSTAIN_FALLS = 3'd6
  } ead_cfg_idx_e;

  typedef struct packed {
    ead_kind_e                     kind;
    logic signed [SampleWidth-1:0] sample;
  } ead_item_t;

  typedef struct packed {
    logic [17:0]        sample_rate;
    logic [15:0]        attack_ms;
    logic [15:0]        decay_ms;
    logic [15:0]        release_ms;
    logic signed [16:0] sustain_level;
    logic [15:0]        sustain_loss_rate;
    logic               sustain_falls;
  } ead_cfg_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } ead_div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quo;
  } ead_div_rsp_t;

  // floor((2^32 - 1) / i) for the series divisions
  function automatic logic [31:0] recip(input logic [3:0] i);
    logic [31:0] r;
    unique case (i)
      4'd1:    r = 32'd4294967295;
      4'd2:    r = 32'd2147483647;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741823;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870911;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/exponential_adsr_envelope.sv
// Exponential ADSR envelope: configuration registers, input queue and sequencer.
// Items are worked one at a time: the next item is taken only after the last result has been
// loaded into the result register. The gain comes from a 12-term series, and phase entries
// that need a step use the iterative divider.
// Reset (async, active low) turns the envelope off, silences the gain, empties the input queue
// and the result register and loads the register defaults.
`default_nettype none

module exponential_adsr_envelope import ead_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    op_i,
  input  wire logic signed [SampleWidth-1:0] sample_in_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [SampleWidth-1:0]      sample_out_o,
  output logic                               voice_free_o,
  output logic [2:0]                         phase_now_o,
  output logic                               voice_ended_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [CfgIdxW-1:0]            cfg_idx_i,
  input  wire logic [CfgW-1:0]               cfg_wdata_i
);

  ead_cfg_t  cfg_q;
  ead_item_t item;
  logic      item_valid, item_pop;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate       <= 18'd48000;
      cfg_q.attack_ms         <= '0;
      cfg_q.decay_ms          <= '0;
      cfg_q.release_ms        <= '0;
      cfg_q.sustain_level     <= SustainMin;
      cfg_q.sustain_loss_rate <= '0;
      cfg_q.sustain_falls     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SAMPLE_RATE:   cfg_q.sample_rate       <= cfg_wdata_i;
        CFG_ATTACK_MS:     cfg_q.attack_ms         <= cfg_wdata_i[15:0];
        CFG_DECAY_MS:      cfg_q.decay_ms          <= cfg_wdata_i[15:0];
        CFG_RELEASE_MS:    cfg_q.release_ms        <= cfg_wdata_i[15:0];
        CFG_SUSTAIN_LEVEL: cfg_q.sustain_level     <= $signed(cfg_wdata_i[16:0]);
        CFG_SUSTAIN_LOSS:  cfg_q.sustain_loss_rate <= cfg_wdata_i[15:0];
        CFG_SUSTAIN_FALLS: cfg_q.sustain_falls     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  ead_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .sample_in_i  (sample_in_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  ead_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (item_valid),
    .item_pop_o    (item_pop),
    .item_i        (item),
    .empty         (empty),
    .pop           (pop),
    .sample_out_o  (sample_out_o),
    .voice_free_o  (voice_free_o),
    .phase_now_o   (phase_now_o),
    .voice_ended_o (voice_ended_o)
  );

endmodule

`default_nettype wire

>>> hdl/ead_front.sv
// Input side: classifies each pushed item and holds it in a short queue.
// Depends on ead_pkg.
`default_nettype none

module ead_front import ead_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    op_i,
  input  wire logic signed [SampleWidth-1:0] sample_in_i,
  output logic                               item_valid_o,
  input  wire logic                          item_pop_i,
  output ead_item_t                          item_o
);

  ead_item_t          mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, rd_q;
  logic [QPtrW:0]     cnt_q;
  logic               do_wr, do_rd;
  ead_item_t          cls;

  assign full         = (cnt_q == (QPtrW+1)'(QDepth)) ? 1'b1 : 1'b0;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];
  assign do_wr        = push && !full;
  assign do_rd        = item_pop_i && item_valid_o;

  // Classify the operation code
  always_comb begin
    cls.sample = sample_in_i;
    unique case (op_i)
      OP_AUDIO:    cls.kind = KIND_AUDIO;
      OP_NOTE_ON:  cls.kind = KIND_ON;
      OP_NOTE_OFF: cls.kind = KIND_OFF;
      default:     cls.kind = KIND_NONE;
    endcase
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wr_q <= wr_q + 1'b1;
      if (do_rd) rd_q <= rd_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (!do_wr && do_rd) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Store the transaction
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_q] <= cls;
  end

endmodule

`default_nettype wire

>>> hdl/ead_div.sv
// Iterative restoring divider, one quotient bit per cycle, shared by the phase entries that need a step.
// Depends on ead_pkg.
`default_nettype none

module ead_div import ead_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  ead_div_req_t req_i,
  output ead_div_rsp_t rsp_o
);

  logic [DivW-1:0]    rem_q, quo_q, den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               done_q;
  logic [DivW:0]      rem_sh, rem_sub;
  logic               ge;

  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  // Count iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == DivCntW'(1));
      if (req_i.start) cnt_q <= DivCntW'(DivW);
      else if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Shift and subtract
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? rem_sub[DivW-1:0] : rem_sh[DivW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> hdl/ead_back.sv
// Execution side: phase sequencer, level ramp, series gain and sample scaling.
// Depends on ead_pkg; uses ead_div for per-phase step computation.
`default_nettype none

module ead_back import ead_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  ead_cfg_t                  cfg_i,
  input  wire logic                 item_valid_i,
  output logic                      item_pop_o,
  input  ead_item_t                 item_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic signed [SampleWidth-1:0] sample_out_o,
  output logic                      voice_free_o,
  output logic [2:0]                phase_now_o,
  output logic                      voice_ended_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_ENTER = 11'b000_0000_0010,
    S_DIV   = 11'b000_0000_0100,
    S_STEP  = 11'b000_0000_1000,
    S_OCT   = 11'b000_0001_0000,
    S_FRAC  = 11'b000_0010_0000,
    S_MUL   = 11'b000_0100_0000,
    S_REC   = 11'b000_1000_0000,
    S_ACC   = 11'b001_0000_0000,
    S_SCALE = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } ead_state_e;

  ead_state_e state_q, state_d;
  ead_phase_e phase_q, phase_d, req_q, req_d, fin;
  logic signed [LevelW-1:0] level_q, level_d;
  logic [StepW-1:0] step_q, step_d;
  logic gz_q, gz_d, ended_q, ended_d, susdiv_q, susdiv_d;
  ead_kind_e kind_q, kind_d;
  logic signed [SampleWidth-1:0] smp_q, smp_d;
  logic [21:0] oct_q, oct_d;
  logic [5:0] nsh_q, nsh_d;
  logic [29:0] x_q, x_d;
  logic [TermW-1:0] term_q, term_d, v_q, v_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [3:0] idx_q, idx_d;
  logic [60:0] prod_q, prod_d;
  logic [62:0] rp_q, rp_d;
  logic signed [55:0] mres_q, mres_d;
  logic res_valid_q, res_valid_d, res_free_q, res_free_d, res_ended_q, res_ended_d;
  logic signed [SampleWidth-1:0] res_smp_q, res_smp_d;
  logic [2:0] res_phase_q, res_phase_d;

  ead_div_req_t div_req;
  ead_div_rsp_t div_rsp;

  // Helper values
  logic [17:0]              rate_hz;
  logic signed [16:0]       sclip;
  logic signed [LevelW-1:0] susq;
  logic [StepW-1:0]         sus_span, rel_span;
  logic [LevelW-1:0]        rel_sum;
  logic [LevelW-1:0]        neg_sus;
  logic [StepW-1:0]         mag;
  logic [LevelW-1:0]        neg_lvl;
  logic [53:0]              oct_prod;
  logic [TblBits+29:0]      x_prod;
  logic [TblBits-1:0]       kfrac;
  logic [TermW-1:0]         q0, qf, r;
  logic [34:0]              qi;
  logic [TermW-1:0]         gclip, gsh;
  logic signed [LevelW:0]   lv;
  logic signed [55:0]       rnd;
  logic signed [25:0]       rs;
  logic signed [SampleWidth-1:0] rclamp;
  logic                     res_load;
  logic [DivW-1:0]          quo;

  ead_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Collapse phases with zero time into the one they skip to
  function automatic ead_phase_e resolve(input ead_phase_e p, input ead_cfg_t c);
    ead_phase_e f;
    unique case (p)
      PH_ATTACK:  f = (c.attack_ms != '0) ? PH_ATTACK :
                      ((c.decay_ms != '0) ? PH_DECAY : PH_SUSTAIN);
      PH_DECAY:   f = (c.decay_ms != '0) ? PH_DECAY : PH_SUSTAIN;
      PH_RELEASE: f = (c.release_ms != '0) ? PH_RELEASE : PH_OFF;
      PH_SUSTAIN: f = PH_SUSTAIN;
      default:    f = PH_OFF;
    endcase
    return f;
  endfunction

  assign rate_hz  = (cfg_i.sample_rate == '0) ? 18'd1 : cfg_i.sample_rate;
  assign sclip    = (cfg_i.sustain_level > 17'sd0) ? 17'sd0 :
                    ((cfg_i.sustain_level < SustainMin) ? SustainMin : cfg_i.sustain_level);
  assign susq     = {sclip, 8'b0};
  assign neg_sus  = -susq;
  assign sus_span = neg_sus[StepW-1:0];
  assign rel_sum  = level_q + {1'b0, FloorSpan};
  assign rel_span = rel_sum[StepW-1:0];
  assign neg_lvl  = -level_q;
  assign mag      = neg_lvl[StepW-1:0];
  assign oct_prod = mag * OctPerDbQ32;
  assign kfrac    = oct_q[15 -: TblBits];
  assign x_prod   = kfrac * Ln2Q30;
  assign fin      = resolve(req_q, cfg_i);
  assign quo      = div_rsp.quo;

  assign q0 = rp_q[62:32];
  assign qi = q0 * idx_q;
  assign r  = v_q - qi[TermW-1:0];
  assign qf = q0 + ((r >= {27'd0, idx_q}) ? 31'd1 : 31'd0);

  assign gclip = sum_q[SumW-1] ? '0 : sum_q[TermW-1:0];
  assign gsh   = (nsh_q > 6'd30) ? '0 : (gclip >> nsh_q);

  assign rnd = mres_q + 56'sd536870912;
  assign rs  = rnd[55:30];
  assign rclamp = (rs > 26'sd8388607) ? 24'sd8388607 :
                  ((rs < -26'sd8388608) ? -24'sd8388608 : rs[SampleWidth-1:0]);

  assign res_load = !res_valid_q || pop;

  assign item_pop_o    = (state_q == S_IDLE) && item_valid_i;
  assign empty         = !res_valid_q;
  assign sample_out_o  = res_smp_q;
  assign voice_free_o  = res_free_q;
  assign phase_now_o   = res_phase_q;
  assign voice_ended_o = res_ended_q;

  // Sequence one item at a time
  always_comb begin
    state_d = state_q;  phase_d = phase_q;  req_d = req_q;
    level_d = level_q;  step_d = step_q;    gz_d = gz_q;
    ended_d = ended_q;  susdiv_d = susdiv_q; kind_d = kind_q; smp_d = smp_q;
    oct_d = oct_q; nsh_d = nsh_q; x_d = x_q; term_d = term_q; v_d = v_q;
    sum_d = sum_q; idx_d = idx_q; prod_d = prod_q; rp_d = rp_q; mres_d = mres_q;
    res_valid_d = res_valid_q && !pop;
    res_smp_d = res_smp_q; res_free_d = res_free_q;
    res_phase_d = res_phase_q; res_ended_d = res_ended_q;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    lv = '0;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          kind_d  = item_i.kind;
          smp_d   = item_i.sample;
          ended_d = 1'b0;
          unique case (item_i.kind)
            KIND_ON: begin
              req_d = PH_ATTACK;
              state_d = S_ENTER;
            end
            KIND_OFF: begin
              req_d = PH_RELEASE;
              state_d = S_ENTER;
            end
            KIND_AUDIO: begin
              // Check phase ends against the present level
              priority if (phase_q == PH_ATTACK && level_q == '0) begin
                req_d = PH_DECAY;
                state_d = S_ENTER;
              end else if (phase_q == PH_DECAY && (level_q < susq || level_q <= FloorDb)) begin
                req_d = PH_SUSTAIN;
                state_d = S_ENTER;
              end else if (phase_q == PH_RELEASE && (gz_q || level_q <= FloorDb)) begin
                ended_d = 1'b1;
                req_d = PH_OFF;
                state_d = S_ENTER;
              end else begin
                state_d = S_STEP;
              end
            end
            default: state_d = S_OUT;
          endcase
        end
      end

      S_ENTER: begin
        phase_d = fin;
        susdiv_d = 1'b0;
        state_d = (kind_q == KIND_AUDIO) ? S_STEP : S_OUT;
        unique case (fin)
          PH_ATTACK: begin
            level_d = FloorDb;
            gz_d = 1'b0;
            div_req.start = 1'b1;
            div_req.num = DivW'(FloorSpan) * DivW'(1000);
            div_req.den = DivW'(cfg_i.attack_ms) * DivW'(rate_hz);
            state_d = S_DIV;
          end
          PH_DECAY: begin
            level_d = '0;
            gz_d = 1'b0;
            div_req.start = 1'b1;
            div_req.num = DivW'(sus_span) * DivW'(1000);
            div_req.den = DivW'(cfg_i.decay_ms) * DivW'(rate_hz);
            state_d = S_DIV;
          end
          PH_SUSTAIN: begin
            if (!cfg_i.sustain_falls) begin
              level_d = susq;
              step_d = '0;
              gz_d = 1'b0;
            end else begin
              susdiv_d = 1'b1;
              div_req.start = 1'b1;
              div_req.num = {10'd0, cfg_i.sustain_loss_rate, 8'd0};
              div_req.den = {16'd0, rate_hz};
              state_d = S_DIV;
            end
          end
          PH_RELEASE: begin
            if (gz_q || level_q <= FloorDb) begin
              step_d = '0;
            end else begin
              div_req.start = 1'b1;
              div_req.num = DivW'(rel_span) * DivW'(1000);
              div_req.den = DivW'(cfg_i.release_ms) * DivW'(rate_hz);
              state_d = S_DIV;
            end
          end
          default: begin
            gz_d = 1'b1;
            step_d = '0;
            level_d = FloorDb;
          end
        endcase
      end

      S_DIV: begin
        if (div_rsp.done) begin
          // Clamp the step into its range
          if (quo > {10'd0, FloorSpan}) step_d = FloorSpan;
          else if (!susdiv_q && quo == '0) step_d = StepW'(1);
          else step_d = quo[StepW-1:0];
          state_d = (kind_q == KIND_AUDIO) ? S_STEP : S_OUT;
        end
      end

      S_STEP: begin
        if (!gz_q && phase_q != PH_OFF) begin
          if (phase_q == PH_ATTACK) lv = level_q + $signed({2'b0, step_q});
          else lv = level_q - $signed({2'b0, step_q});
          if (lv > 26'sd0) level_d = '0;
          else if (lv < FloorDb) level_d = FloorDb;
          else level_d = lv[LevelW-1:0];
        end
        state_d = gz_q ? S_OUT : S_OCT;
      end

      S_OCT: begin
        oct_d = oct_prod[53:32];
        state_d = S_FRAC;
      end

      S_FRAC: begin
        nsh_d  = oct_q[21:16];
        x_d    = x_prod[TblBits+29:TblBits];
        term_d = OneQ30;
        sum_d  = {2'b0, OneQ30};
        idx_d  = 4'd1;
        state_d = S_MUL;
      end

      S_MUL: begin
        prod_d = term_q * x_q;
        state_d = S_REC;
      end

      S_REC: begin
        v_d  = prod_q[60:30];
        rp_d = prod_q[60:30] * recip(idx_q);
        state_d = S_ACC;
      end

      S_ACC: begin
        term_d = qf;
        sum_d  = idx_q[0] ? (sum_q - $signed({2'b0, qf})) : (sum_q + $signed({2'b0, qf}));
        idx_d  = idx_q + 1'b1;
        state_d = (idx_q == 4'(SeriesTerms)) ? S_SCALE : S_MUL;
      end

      S_SCALE: begin
        mres_d = smp_q * $signed({1'b0, gsh});
        state_d = S_OUT;
      end

      S_OUT: begin
        // Hold until the result register frees up
        if (res_load) begin
          res_valid_d = 1'b1;
          res_smp_d   = (kind_q == KIND_AUDIO && !gz_q) ? rclamp : '0;
          res_free_d  = (phase_q == PH_OFF);
          res_phase_d = phase_q;
          res_ended_d = ended_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control and envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_OFF;
      level_q     <= '0;
      step_q      <= '0;
      gz_q        <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      level_q     <= level_d;
      step_q      <= step_d;
      gz_q        <= gz_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;  ended_q <= ended_d;  susdiv_q <= susdiv_d;
    kind_q <= kind_d; smp_q <= smp_d;
    oct_q <= oct_d; nsh_q <= nsh_d; x_q <= x_d; term_q <= term_d; v_q <= v_d;
    sum_q <= sum_d; idx_q <= idx_d; prod_q <= prod_d; rp_q <= rp_d; mres_q <= mres_d;
    res_smp_q <= res_smp_d; res_free_q <= res_free_d;
    res_phase_q <= res_phase_d; res_ended_q <= res_ended_d;
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the exponential ADSR envelope: a behavioral predictor
// follows every accepted transaction and checks each popped result. Depends on ead_pkg.
`default_nettype none

module testbench;
  import ead_pkg::*;

  typedef struct {
    logic [SampleWidth-1:0] smp;
    logic                   free;
    logic [2:0]             ph;
    logic                   ended;
  } env_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   push = 1'b0;
  logic                   full;
  logic [1:0]             op_i = OP_AUDIO;
  logic [SampleWidth-1:0] sample_in_i = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [SampleWidth-1:0] sample_out_o;
  logic                   voice_free_o;
  logic [2:0]             phase_now_o;
  logic                   voice_ended_o;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i = '0;
  logic [CfgW-1:0]        cfg_wdata_i = '0;

  exponential_adsr_envelope dut (
    .clk_i, .rst_ni, .push, .full, .op_i, .sample_in_i, .empty, .pop,
    .sample_out_o, .voice_free_o, .phase_now_o, .voice_ended_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  // Register copies and envelope state of the predictor
  logic [17:0] rate_reg;
  logic [15:0] attack_reg, decay_reg, release_reg, loss_reg;
  logic [16:0] sustain_reg;
  logic        falls_reg;
  ead_phase_e  env_phase;
  longint      env_level;
  longint      env_step;
  bit          env_silent;

  env_result_t expected_q[$];
  logic [CfgW-1:0] setting_vals [7];
  int items_sent, results_checked, mismatches, settings_loaded, ended_seen;
  int send_idle_pct, recv_idle_pct, hold_cycles;

  // Clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard limit on the run
  initial begin
    #(4 * 4_000_000);
    $display("status: fail");
    $finish;
  end

  function automatic longint eff_rate();
    return (rate_reg == 0) ? 1 : longint'(rate_reg);
  endfunction

  function automatic longint sustain_q16();
    longint s;
    s = longint'($signed(sustain_reg));
    if (s > 0) s = 0;
    if (s < -46080) s = -46080;
    return s * 256;
  endfunction

  function automatic longint ramp_step(longint span, longint ms);
    longint q;
    q = span * 1000 / (ms * eff_rate());
    if (q < 1) q = 1;
    if (q > longint'(FloorSpan)) q = longint'(FloorSpan);
    return q;
  endfunction

  // Enter a phase; zero times fall through to the next phase
  function automatic void enter_phase(ead_phase_e p);
    bit again;
    longint q;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      env_phase = p;
      case (p)
        PH_ATTACK: begin
          if (attack_reg == 0) begin
            p = PH_DECAY;
            again = 1'b1;
          end else begin
            env_step = ramp_step(longint'(FloorSpan), attack_reg);
            env_level = -longint'(FloorSpan);
            env_silent = 1'b0;
          end
        end
        PH_DECAY: begin
          if (decay_reg == 0) begin
            p = PH_SUSTAIN;
            again = 1'b1;
          end else begin
            env_level = 0;
            env_silent = 1'b0;
            env_step = ramp_step(-sustain_q16(), decay_reg);
          end
        end
        PH_SUSTAIN: begin
          if (!falls_reg) begin
            env_level = sustain_q16();
            env_step = 0;
            env_silent = 1'b0;
          end else begin
            q = longint'(loss_reg) * 256 / eff_rate();
            if (q > longint'(FloorSpan)) q = longint'(FloorSpan);
            env_step = q;
          end
        end
        PH_RELEASE: begin
          if (release_reg == 0) begin
            p = PH_OFF;
            again = 1'b1;
          end else if (env_silent || env_level <= -longint'(FloorSpan)) begin
            env_step = 0;
          end else begin
            env_step = ramp_step(env_level + longint'(FloorSpan), release_reg);
          end
        end
        default: begin
          env_phase = PH_OFF;
          env_silent = 1'b1;
          env_step = 0;
          env_level = -longint'(FloorSpan);
        end
      endcase
    end
  endfunction

  // Linear gain in Q30 from a Q16 dB level
  function automatic longint gain_q30(longint lv);
    longint mag, o, n, k, x, term, sum;
    mag = (lv < 0) ? -lv : 0;
    o = (mag * longint'(OctPerDbQ32)) >> 32;
    n = o >> 16;
    k = ((o & 16'hFFFF) * GainTableDepth) >> 16;
    if (n > 30) return 0;
    x = k * longint'(Ln2Q30) / GainTableDepth;
    term = longint'(OneQ30);
    sum = longint'(OneQ30);
    for (int i = 1; i <= SeriesTerms; i++) begin
      term = ((term * x) >> 30) / i;
      if (i % 2 == 1) sum -= term;
      else sum += term;
    end
    if (sum < 0) sum = 0;
    return sum >> n;
  endfunction

  // Advance the envelope by one transaction and form its result
  function automatic env_result_t envelope_next(logic [1:0] op, logic [SampleWidth-1:0] smp);
    env_result_t r;
    longint lv, prod, outv;
    r.smp = '0;
    r.ended = 1'b0;
    case (ead_op_e'(op))
      OP_NOTE_ON:  enter_phase(PH_ATTACK);
      OP_NOTE_OFF: enter_phase(PH_RELEASE);
      OP_AUDIO: begin
        if (env_phase == PH_ATTACK && env_level >= 0) enter_phase(PH_DECAY);
        if (env_phase == PH_DECAY &&
            (env_level < sustain_q16() || env_level <= -longint'(FloorSpan)))
          enter_phase(PH_SUSTAIN);
        if (env_phase == PH_RELEASE && (env_silent || env_level <= -longint'(FloorSpan))) begin
          r.ended = 1'b1;
          enter_phase(PH_OFF);
        end
        if (!env_silent && env_phase != PH_OFF) begin
          lv = (env_phase == PH_ATTACK) ? env_level + env_step : env_level - env_step;
          if (lv > 0) lv = 0;
          if (lv < -longint'(FloorSpan)) lv = -longint'(FloorSpan);
          env_level = lv;
        end
        if (!env_silent) begin
          prod = longint'($signed(smp)) * gain_q30(env_level);
          outv = (prod + (longint'(1) << 29)) >>> 30;
          if (outv > 8388607) outv = 8388607;
          if (outv < -8388608) outv = -8388608;
          r.smp = outv[SampleWidth-1:0];
        end
      end
      default: ;
    endcase
    r.free = (env_phase == PH_OFF);
    r.ph = env_phase;
    return r;
  endfunction

  // Offer one transaction, idling cycle by cycle at the current rate
  task automatic send_item(ead_op_e op, logic [SampleWidth-1:0] smp);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    op_i <= op;
    sample_in_i <= smp;
    do @(posedge clk_i); while (full);
    expected_q.push_back(envelope_next(op, smp));
    items_sent++;
  endtask

  task automatic send_audio();
    send_item(OP_AUDIO, SampleWidth'($urandom));
  endtask

  // Drop push and wait until every result is out and the block is idle
  task automatic drain();
    push <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Write all registers from setting_vals while the block is idle
  task automatic load_settings();
    drain();
    for (int i = 0; i < 7; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CfgIdxW'(i);
      cfg_wdata_i <= setting_vals[i];
      @(posedge clk_i);
      case (ead_cfg_idx_e'(i))
        CFG_SAMPLE_RATE:   rate_reg = setting_vals[i][17:0];
        CFG_ATTACK_MS:     attack_reg = setting_vals[i][15:0];
        CFG_DECAY_MS:      decay_reg = setting_vals[i][15:0];
        CFG_RELEASE_MS:    release_reg = setting_vals[i][15:0];
        CFG_SUSTAIN_LEVEL: sustain_reg = setting_vals[i][16:0];
        CFG_SUSTAIN_LOSS:  loss_reg = setting_vals[i][15:0];
        default:           falls_reg = setting_vals[i][0];
      endcase
    end
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  function automatic logic [CfgW-1:0] pick_ms();
    case ($urandom_range(7))
      0: return '0;
      1: return CfgW'(16'hFFFF);
      default: return CfgW'($urandom_range(1, 3));
    endcase
  endfunction

  // Mostly short ramps so phases finish within a few dozen samples
  task automatic random_settings();
    case ($urandom_range(7))
      0: setting_vals[CFG_SAMPLE_RATE] = '0;
      1: setting_vals[CFG_SAMPLE_RATE] = 18'h3FFFF;
      2: setting_vals[CFG_SAMPLE_RATE] = 18'd192000;
      default: setting_vals[CFG_SAMPLE_RATE] = CfgW'($urandom_range(500, 12000));
    endcase
    setting_vals[CFG_ATTACK_MS] = pick_ms();
    setting_vals[CFG_DECAY_MS] = pick_ms();
    setting_vals[CFG_RELEASE_MS] = pick_ms();
    case ($urandom_range(5))
      0: setting_vals[CFG_SUSTAIN_LEVEL] = 18'h0FFFF;
      1: setting_vals[CFG_SUSTAIN_LEVEL] = 18'h10000;
      2: setting_vals[CFG_SUSTAIN_LEVEL] = CfgW'(17'(-46080));
      3: setting_vals[CFG_SUSTAIN_LEVEL] = '0;
      default: setting_vals[CFG_SUSTAIN_LEVEL] = CfgW'(17'(-$urandom_range(0, 46080)));
    endcase
    setting_vals[CFG_SUSTAIN_LOSS] = ($urandom_range(3) == 0) ? CfgW'(16'hFFFF) :
                                     CfgW'($urandom_range(65535));
    setting_vals[CFG_SUSTAIN_FALLS] = CfgW'($urandom_range(1));
    load_settings();
  endtask

  // Check each popped transaction; hold off pop when asked
  initial begin
    env_result_t e;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", sample_out_o);
        end else begin
          e = expected_q.pop_front();
          results_checked++;
          if (voice_ended_o) ended_seen++;
          if (sample_out_o !== e.smp || voice_free_o !== e.free ||
              phase_now_o !== e.ph || voice_ended_o !== e.ended) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp smp=%h free=%b ph=%0d end=%b, got %h %b %0d %b",
                       results_checked, e.smp, e.free, e.ph, e.ended,
                       sample_out_o, voice_free_o, phase_now_o, voice_ended_o);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Triggers and odd ops at reset values, then sample extremes at 0 dB sustain
  task automatic test_directed();
    send_item(OP_RSVD, 24'h7FFFFF);
    send_item(OP_AUDIO, 24'h123456);
    send_item(OP_NOTE_OFF, 0);
    send_item(OP_NOTE_ON, 0);
    send_item(OP_AUDIO, 24'h7FFFFF);
    send_item(OP_NOTE_OFF, 0);
    send_item(OP_AUDIO, 24'h7FFFFF);
    setting_vals = '{8000, 0, 0, 2, 0, 0, 0};
    load_settings();
    send_item(OP_NOTE_OFF, 0);
    send_item(OP_AUDIO, 24'h000001);
    send_item(OP_NOTE_ON, 0);
    send_item(OP_AUDIO, 24'h7FFFFF);
    send_item(OP_AUDIO, 24'h800000);
    send_item(OP_AUDIO, 24'h000000);
    send_item(OP_AUDIO, 24'hFFFFFF);
    send_item(OP_RSVD, 24'h800000);
    send_item(OP_NOTE_OFF, 0);
    repeat (18) send_audio();
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    setting_vals = '{4000, 1, 1, 1, CfgW'(17'(-6000)), 0, 0};
    load_settings();
    hold_cycles = 600;
    send_item(OP_NOTE_ON, 0);
    repeat (30) send_audio();
    send_item(OP_NOTE_OFF, 0);
    repeat (10) send_audio();
    drain();
  endtask

  // Notes with random content under changing settings, plus some noise
  task automatic test_random_notes(int target);
    int n;
    while (items_sent < target) begin
      if (items_sent < target / 3) begin
        send_idle_pct = 36; recv_idle_pct = 61;
      end else if (items_sent < 2 * target / 3) begin
        send_idle_pct = 61; recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      random_settings();
      repeat ($urandom_range(1, 3)) begin
        send_item(OP_NOTE_ON, SampleWidth'($urandom));
        n = $urandom_range(0, 40);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(19) == 0) send_item(ead_op_e'($urandom_range(3)), SampleWidth'($urandom));
          else send_audio();
        end
        if ($urandom_range(5) != 0) send_item(OP_NOTE_OFF, SampleWidth'($urandom));
        repeat ($urandom_range(0, 30)) send_audio();
      end
    end
    drain();
  endtask

  initial begin
    rate_reg = 48000; attack_reg = 0; decay_reg = 0; release_reg = 0;
    sustain_reg = 17'(-46080); loss_reg = 0; falls_reg = 1'b0;
    env_phase = PH_OFF; env_level = 0; env_step = 0; env_silent = 1'b1;
    send_idle_pct = 36; recv_idle_pct = 61; hold_cycles = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_notes(1550);
    $display("covered %0d transactions, %0d results, %0d register settings, %0d voice ends",
             items_sent, results_checked, settings_loaded, ended_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
